>>> hdl/rhs_pkg.sv
// Shared types, constants and register map of the ramp-hold-step setpoint sequencer.
package rhs_pkg;

  localparam int MAX_JOINTS  = 16;
  localparam int JOINT_IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  localparam int ACT_W     = 16;
  localparam int FRAME_W   = 16;
  localparam int DIV_STEPS = FRAME_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [FRAME_W-1:0] RAMP_LEN_RST = FRAME_W'(50);
  localparam logic [FRAME_W-1:0] HOLD_LEN_RST = FRAME_W'(50);
  localparam logic [FRAME_W-1:0] FRAME_MAX    = {FRAME_W{1'b1}};

  typedef enum logic [1:0] {
    REG_TEST_ENABLE = 2'd0,
    REG_RAMP_LEN    = 2'd1,
    REG_HOLD_LEN    = 2'd2
  } rhs_reg_e;

  typedef enum logic [1:0] {
    PH_PASS   = 2'd0,
    PH_RAMP   = 2'd1,
    PH_HOLD   = 2'd2,
    PH_TARGET = 2'd3
  } rhs_phase_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RAMP   = 4'b0010,
    ST_HOLD   = 4'b0100,
    ST_TARGET = 4'b1000
  } rhs_stage_e;

  typedef enum logic [3:0] {
    DIV_IDLE = 4'b0001,
    DIV_MUL  = 4'b0010,
    DIV_STEP = 4'b0100,
    DIV_DONE = 4'b1000
  } rhs_div_state_e;

  typedef struct packed {
    logic [3:0]              joint_index;
    logic signed [ACT_W-1:0] policy_action;
    logic signed [ACT_W-1:0] start_value;
    logic signed [ACT_W-1:0] target_value;
    logic                    tick_end;
    logic                    model_reloaded;
  } rhs_in_t;

  typedef struct packed {
    logic [3:0]              out_joint;
    logic signed [ACT_W-1:0] commanded_action;
    logic [1:0]              phase;
    logic                    out_tick_end;
  } rhs_out_t;

  typedef struct packed {
    logic               test_enable;
    logic [FRAME_W-1:0] ramp_len;
    logic [FRAME_W-1:0] hold_len;
  } rhs_cfg_t;

  // Work handed to the arithmetic unit for one item.
  typedef struct packed {
    logic                    bypass;
    logic signed [ACT_W-1:0] direct;
    logic signed [ACT_W-1:0] a0;
    logic signed [ACT_W-1:0] a1;
    logic [FRAME_W-1:0]      n;
    logic [FRAME_W-1:0]      rf;
  } rhs_op_t;

endpackage

>>> hdl/rhs_cfg.sv
// APB configuration registers of the sequencer.
module rhs_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rhs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rhs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rhs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output rhs_pkg::rhs_cfg_t                  cfg_o
);

  rhs_pkg::rhs_cfg_t cfg_q;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.test_enable <= 1'b0;
      cfg_q.ramp_len    <= rhs_pkg::RAMP_LEN_RST;
      cfg_q.hold_len    <= rhs_pkg::HOLD_LEN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        rhs_pkg::REG_TEST_ENABLE: cfg_q.test_enable <= pwdata[0];
        rhs_pkg::REG_RAMP_LEN:    cfg_q.ramp_len    <= pwdata[rhs_pkg::FRAME_W-1:0];
        rhs_pkg::REG_HOLD_LEN:    cfg_q.hold_len    <= pwdata[rhs_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rhs_pkg::REG_TEST_ENABLE: prdata = rhs_pkg::APB_DATA_W'(cfg_q.test_enable);
      rhs_pkg::REG_RAMP_LEN:    prdata = rhs_pkg::APB_DATA_W'(cfg_q.ramp_len);
      rhs_pkg::REG_HOLD_LEN:    prdata = rhs_pkg::APB_DATA_W'(cfg_q.hold_len);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/rhs_seq.sv
// Sequence state, frame counters and per-joint capture store.
module rhs_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  rhs_pkg::rhs_in_t     item_i,
  input  rhs_pkg::rhs_cfg_t    cfg_i,
  output rhs_pkg::rhs_op_t     op_o,
  output logic [1:0]           phase_o
);

  rhs_pkg::rhs_stage_e                      stage_q, stage_d;
  logic                                     armed_q, armed_d;
  logic                                     arming_q, arming_d;
  logic [rhs_pkg::FRAME_W-1:0]              ramp_cnt_q, ramp_cnt_d;
  logic [rhs_pkg::FRAME_W-1:0]              delay_cnt_q, delay_cnt_d;
  logic signed [rhs_pkg::ACT_W-1:0]         capture_q [rhs_pkg::MAX_JOINTS];

  logic [rhs_pkg::FRAME_W-1:0]              rf, df;
  logic [rhs_pkg::FRAME_W:0]                ramp_n;
  logic                                     joint_ok;
  logic [rhs_pkg::JOINT_IDX_W-1:0]          joint_idx;
  logic                                     cap_en;

  // A frame count of zero behaves as one.
  assign rf = (cfg_i.ramp_len == '0) ? rhs_pkg::FRAME_W'(1) : cfg_i.ramp_len;
  assign df = (cfg_i.hold_len == '0) ? rhs_pkg::FRAME_W'(1) : cfg_i.hold_len;

  assign joint_ok  = 32'(item_i.joint_index) < 32'(rhs_pkg::MAX_JOINTS);
  assign joint_idx = rhs_pkg::JOINT_IDX_W'(item_i.joint_index);

  always_comb begin
    stage_d     = stage_q;
    armed_d     = armed_q;
    arming_d    = arming_q;
    ramp_cnt_d  = ramp_cnt_q;
    delay_cnt_d = delay_cnt_q;
    cap_en      = 1'b0;
    ramp_n      = '0;
    phase_o     = rhs_pkg::PH_PASS;
    op_o.bypass = 1'b1;
    op_o.direct = item_i.policy_action;

    // Reload restarts first; a disabled block then restarts as well.
    if (item_i.model_reloaded || !cfg_i.test_enable) begin
      stage_d     = rhs_pkg::ST_IDLE;
      armed_d     = 1'b0;
      arming_d    = 1'b0;
      ramp_cnt_d  = '0;
      delay_cnt_d = '0;
    end

    if (cfg_i.test_enable) begin
      if (!armed_d) begin
        armed_d     = 1'b1;
        stage_d     = rhs_pkg::ST_RAMP;
        ramp_cnt_d  = '0;
        delay_cnt_d = '0;
        arming_d    = 1'b1;
      end
      cap_en = arming_d && joint_ok;

      case (stage_d)
        rhs_pkg::ST_RAMP: begin
          phase_o = rhs_pkg::PH_RAMP;
          ramp_n  = {1'b0, ramp_cnt_d} + (rhs_pkg::FRAME_W+1)'(1);
          if (ramp_n >= {1'b0, rf}) begin
            op_o.direct = item_i.start_value;
          end else begin
            op_o.bypass = 1'b0;
          end
          if (item_i.tick_end) begin
            if (ramp_cnt_d != rhs_pkg::FRAME_MAX) begin
              ramp_cnt_d = ramp_cnt_d + rhs_pkg::FRAME_W'(1);
            end
            if (ramp_cnt_d >= rf) begin
              stage_d     = rhs_pkg::ST_HOLD;
              delay_cnt_d = '0;
            end
          end
        end
        rhs_pkg::ST_HOLD: begin
          phase_o     = rhs_pkg::PH_HOLD;
          op_o.direct = item_i.start_value;
          if (item_i.tick_end) begin
            if (delay_cnt_d != rhs_pkg::FRAME_MAX) begin
              delay_cnt_d = delay_cnt_d + rhs_pkg::FRAME_W'(1);
            end
            if (delay_cnt_d >= df) begin
              stage_d = rhs_pkg::ST_TARGET;
            end
          end
        end
        rhs_pkg::ST_TARGET: begin
          phase_o     = rhs_pkg::PH_TARGET;
          op_o.direct = item_i.target_value;
        end
        default: begin
          op_o.direct = item_i.target_value;
        end
      endcase
    end

    if (item_i.tick_end) begin
      arming_d = 1'b0;
    end

    // Interpolation operands; an arming item ramps from its own action.
    op_o.a1 = item_i.start_value;
    op_o.n  = ramp_n[rhs_pkg::FRAME_W-1:0];
    op_o.rf = rf;
    if (cap_en) begin
      op_o.a0 = item_i.policy_action;
    end else if (joint_ok) begin
      op_o.a0 = capture_q[joint_idx];
    end else begin
      op_o.a0 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= rhs_pkg::ST_IDLE;
      armed_q     <= 1'b0;
      arming_q    <= 1'b0;
      ramp_cnt_q  <= '0;
      delay_cnt_q <= '0;
    end else if (accept_i) begin
      stage_q     <= stage_d;
      armed_q     <= armed_d;
      arming_q    <= arming_d;
      ramp_cnt_q  <= ramp_cnt_d;
      delay_cnt_q <= delay_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && cap_en) begin
      capture_q[joint_idx] <= item_i.policy_action;
    end
  end

endmodule

>>> hdl/rhs_div.sv
// Shared multiply and shift-subtract divide unit for the ramp interpolation.
module rhs_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             go_i,
  input  rhs_pkg::rhs_op_t                 op_i,
  input  logic                             take_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic signed [rhs_pkg::ACT_W-1:0] result_o
);

  rhs_pkg::rhs_div_state_e          state_q, state_d;
  logic                             bypass_q;
  logic signed [rhs_pkg::ACT_W-1:0] direct_q;
  logic signed [rhs_pkg::ACT_W-1:0] a0_q;
  logic [rhs_pkg::FRAME_W-1:0]      rf_q;
  logic [rhs_pkg::FRAME_W-1:0]      n_q;
  logic [rhs_pkg::ACT_W-1:0]        mag_q;
  logic                             neg_q;
  logic [rhs_pkg::FRAME_W-1:0]      rem_q;
  logic [rhs_pkg::FRAME_W-1:0]      quo_q;
  logic [rhs_pkg::STEP_W-1:0]       step_q;

  logic signed [rhs_pkg::ACT_W:0]   diff;
  logic signed [rhs_pkg::ACT_W:0]   diff_abs;
  logic [2*rhs_pkg::FRAME_W-1:0]    prod;
  logic [rhs_pkg::FRAME_W+1:0]      trial;
  logic                             fits;
  logic signed [rhs_pkg::ACT_W:0]   q_signed;
  logic signed [rhs_pkg::ACT_W:0]   sum;

  // |a1 - a0| never exceeds 16 bits; keep the sign aside.
  assign diff     = {op_i.a1[rhs_pkg::ACT_W-1], op_i.a1} - {op_i.a0[rhs_pkg::ACT_W-1], op_i.a0};
  assign diff_abs = diff[rhs_pkg::ACT_W] ? -diff : diff;

  assign prod  = rhs_pkg::ACT_W'(mag_q) * n_q;
  assign trial = {1'b0, rem_q, quo_q[rhs_pkg::FRAME_W-1]} - {2'b00, rf_q};
  assign fits  = !trial[rhs_pkg::FRAME_W+1];

  assign q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sum      = {a0_q[rhs_pkg::ACT_W-1], a0_q} + q_signed;
  assign result_o = bypass_q ? direct_q : sum[rhs_pkg::ACT_W-1:0];

  assign busy_o = (state_q != rhs_pkg::DIV_IDLE);
  assign done_o = (state_q == rhs_pkg::DIV_DONE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rhs_pkg::DIV_IDLE: if (go_i) begin
        state_d = op_i.bypass ? rhs_pkg::DIV_DONE : rhs_pkg::DIV_MUL;
      end
      rhs_pkg::DIV_MUL:  state_d = rhs_pkg::DIV_STEP;
      rhs_pkg::DIV_STEP: if (step_q == rhs_pkg::STEP_W'(rhs_pkg::DIV_STEPS - 1)) begin
        state_d = rhs_pkg::DIV_DONE;
      end
      rhs_pkg::DIV_DONE: if (take_i) begin
        state_d = rhs_pkg::DIV_IDLE;
      end
      default:           state_d = rhs_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhs_pkg::DIV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rhs_pkg::DIV_MUL) begin
        step_q <= '0;
      end else if (state_q == rhs_pkg::DIV_STEP) begin
        step_q <= step_q + rhs_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rhs_pkg::DIV_IDLE: if (go_i) begin
        bypass_q <= op_i.bypass;
        direct_q <= op_i.direct;
        a0_q     <= op_i.a0;
        rf_q     <= op_i.rf;
        n_q      <= op_i.n;
        mag_q    <= diff_abs[rhs_pkg::ACT_W-1:0];
        neg_q    <= diff[rhs_pkg::ACT_W];
      end
      rhs_pkg::DIV_MUL: begin
        // Quotient stays below |a1 - a0|, so the high half is already below rf.
        rem_q <= prod[2*rhs_pkg::FRAME_W-1:rhs_pkg::FRAME_W];
        quo_q <= prod[rhs_pkg::FRAME_W-1:0];
      end
      rhs_pkg::DIV_STEP: begin
        rem_q <= fits ? trial[rhs_pkg::FRAME_W-1:0]
                      : {rem_q[rhs_pkg::FRAME_W-2:0], quo_q[rhs_pkg::FRAME_W-1]};
        quo_q <= {quo_q[rhs_pkg::FRAME_W-2:0], fits};
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/ramp_hold_step_setpoint_sequencer.sv
// Top level of the ramp-hold-step setpoint sequencer.
// Ramp items: a multiply, the 16 shift-subtract steps of the shared divide unit and an
//   add, then the output register.
// Passthrough, hold, target and final-ramp items go straight to the same unit's result
//   slot, then the output register; one item is in flight at a time.
// Reset (rst_ni low, asynchronous): sequence idle, counters cleared, registers at
//   defaults; the per-joint capture store is not cleared and needs no clearing pass.
module ramp_hold_step_setpoint_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rhs_pkg::rhs_in_t               in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rhs_pkg::rhs_out_t              out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rhs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rhs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rhs_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  rhs_pkg::rhs_cfg_t                cfg;
  rhs_pkg::rhs_op_t                 op;
  logic [1:0]                       phase;
  logic                             accept;
  logic                             div_busy;
  logic                             div_done;
  logic                             take;
  logic                             out_free;
  logic signed [rhs_pkg::ACT_W-1:0] div_result;

  // Per-item fields that ride alongside the arithmetic.
  logic [3:0]                       joint_q;
  logic [1:0]                       phase_q;
  logic                             tick_end_q;

  logic                             out_valid_q;
  rhs_pkg::rhs_out_t                out_item_q;

  rhs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stall while the unit holds an item: one item in flight at a time.
  assign in_stall_o = div_busy;
  assign accept     = in_valid_i && !in_stall_o;

  // Sequence state advances on the transfer; it also picks the operands.
  rhs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg),
    .op_o     (op),
    .phase_o  (phase)
  );

  // Items that need no interpolation pass straight to the result slot.
  rhs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (accept),
    .op_i     (op),
    .take_i   (take),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .result_o (div_result)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      joint_q    <= in_item_i.joint_index;
      phase_q    <= phase;
      tick_end_q <= in_item_i.tick_end;
    end
  end

  // Output register: load the finished result whenever the slot is free or leaving.
  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = div_done && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_item_q.out_joint        <= joint_q;
      out_item_q.commanded_action <= div_result;
      out_item_q.phase            <= phase_q;
      out_item_q.out_tick_end     <= tick_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A transfer always occupies the unit on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input transfer did not occupy the arithmetic unit");

  // A finished result with a free slot shows up at the output.
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done && out_free) |=> (out_valid_o && !div_done))
    else $error("finished result not moved to the output register");

  // A new result only appears after the unit finished.
  a_rise_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(div_done))
    else $error("output valid rose without a finished result");

endmodule

>>> tb/ramp_hold_step_setpoint_sequencer_tb.sv
// Self-checking testbench for the ramp-hold-step setpoint sequencer.
module ramp_hold_step_setpoint_sequencer_tb;
  import rhs_pkg::*;

  // Idle time allowed after the last expected result, before registers are written.
  localparam int SETTLE_CYCLES = 24;
  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int HANG_LIMIT    = 3000;
  // Receiver hold-off that backs the block up into its input.
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 105;
  localparam int NUM_PHASES    = 8;

  typedef struct {
    bit          is_cfg;
    bit          en;
    logic [15:0] rf;
    logic [15:0] df;
    rhs_in_t     it;
    bit          typed;
    rhs_out_t    want;
  } dir_row_t;

  typedef struct {
    bit          en;
    logic [15:0] rf;
    logic [15:0] df;
  } cfg_set_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  rhs_in_t               in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rhs_out_t              out_item_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ramp_hold_step_setpoint_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Register shadow, updated on every write.
  bit          cfg_enable   = 1'b0;
  logic [15:0] cfg_ramp_len = RAMP_LEN_RST;
  logic [15:0] cfg_hold_len = HOLD_LEN_RST;

  // Sequencer state as the block should hold it.
  rhs_phase_e         seq_stage  = PH_PASS;
  bit                 seq_armed  = 1'b0;
  bit                 seq_arming = 1'b0;
  int unsigned        ramp_ticks = 0;
  int unsigned        hold_ticks = 0;
  logic signed [15:0] captured_q411 [16];
  bit                 captured_ok   [16];

  rhs_out_t setpoints_due [$];
  dir_row_t dir_tab [$];
  cfg_set_t plan [NUM_PHASES];

  int       err_cnt       = 0;
  int       quiet_cycles  = 0;
  bit       idle_on       = 1'b1;
  bit       long_hold_req = 1'b0;
  int       stall_left    = 0;
  rhs_out_t want_res;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_err(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // Work out the result of one transfer and advance the sequencer state.
  function automatic rhs_out_t predict_setpoint(rhs_in_t it);
    rhs_out_t    res;
    int unsigned rf;
    int unsigned df;
    int unsigned n;
    longint      a0;
    longint      delta;
    res.out_joint        = it.joint_index;
    res.commanded_action = it.policy_action;
    res.phase            = PH_PASS;
    res.out_tick_end     = it.tick_end;
    // A zero frame count behaves as one.
    rf = (cfg_ramp_len == 0) ? 1 : cfg_ramp_len;
    df = (cfg_hold_len == 0) ? 1 : cfg_hold_len;
    // Reload is applied before the enable check; both drop the sequence to idle.
    if (it.model_reloaded || !cfg_enable) begin
      seq_armed  = 1'b0;
      seq_stage  = PH_PASS;
      ramp_ticks = 0;
      hold_ticks = 0;
      seq_arming = 1'b0;
    end
    if (cfg_enable) begin
      if (!seq_armed) begin
        seq_armed  = 1'b1;
        seq_stage  = PH_RAMP;
        ramp_ticks = 0;
        hold_ticks = 0;
        seq_arming = 1'b1;
      end
      // Every item of the arming tick captures its own action.
      if (seq_arming) begin
        captured_q411[it.joint_index] = it.policy_action;
        captured_ok[it.joint_index]   = 1'b1;
      end
      res.phase = seq_stage;
      case (seq_stage)
        PH_RAMP: begin
          n = ramp_ticks + 1;
          if (n >= rf) begin
            res.commanded_action = it.start_value;
          end else begin
            a0    = captured_q411[it.joint_index];
            delta = (longint'(it.start_value) - a0) * longint'(n);
            // Signed division truncates toward zero, as the lerp requires.
            res.commanded_action = 16'(a0 + delta / longint'(rf));
          end
          if (it.tick_end) begin
            if (ramp_ticks < 65535) ramp_ticks++;
            if (ramp_ticks >= rf) begin
              seq_stage  = PH_HOLD;
              hold_ticks = 0;
            end
          end
        end
        PH_HOLD: begin
          res.commanded_action = it.start_value;
          if (it.tick_end) begin
            if (hold_ticks < 65535) hold_ticks++;
            if (hold_ticks >= df) seq_stage = PH_TARGET;
          end
        end
        default: begin
          res.commanded_action = it.target_value;
        end
      endcase
    end
    if (it.tick_end) seq_arming = 1'b0;
    return res;
  endfunction

  // True when the item would ramp from a capture slot never written.
  function automatic bit ramp_reads_blank(rhs_in_t it);
    int unsigned rf;
    rf = (cfg_ramp_len == 0) ? 1 : cfg_ramp_len;
    if (!cfg_enable || it.model_reloaded || !seq_armed || seq_arming) return 1'b0;
    if (seq_stage != PH_RAMP || ramp_ticks + 1 >= rf) return 1'b0;
    return !captured_ok[it.joint_index];
  endfunction

  // Bias Q4.11 values toward the extremes and zero.
  function automatic logic signed [15:0] draw_q411();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one transfer; called and returning at a falling edge.
  task automatic send_setpoint(rhs_in_t it, bit typed, rhs_out_t typed_want);
    rhs_out_t    res;
    int unsigned j;
    // Steer away from a capture slot that was never written.
    if (ramp_reads_blank(it)) begin
      do j = $urandom_range(15); while (!captured_ok[j]);
      it.joint_index = 4'(j);
    end
    if (idle_on && $urandom_range(4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = predict_setpoint(it);
    setpoints_due.insert(setpoints_due.size(), typed ? typed_want : res);
    @(negedge clk_i);
  endtask

  // Drop valid, wait out every expected result, then let the block settle.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (setpoints_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write one register, read it back and update the shadow.
  task automatic write_reg(rhs_reg_e idx, logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_TEST_ENABLE: begin
        want       = val & 32'h1;
        cfg_enable = val[0];
      end
      REG_RAMP_LEN: begin
        want         = val & 32'hFFFF;
        cfg_ramp_len = val[15:0];
      end
      default: begin
        want         = val & 32'hFFFF;
        cfg_hold_len = val[15:0];
      end
    endcase
    if (rd !== want) flag_err($sformatf("readback of reg %s: want %0h got %0h",
                                        idx.name(), want, rd));
  endtask

  task automatic apply_cfg(bit en, logic [15:0] rf, logic [15:0] df);
    write_reg(REG_TEST_ENABLE, {31'b0, en});
    write_reg(REG_RAMP_LEN, {16'b0, rf});
    write_reg(REG_HOLD_LEN, {16'b0, df});
  endtask

  task automatic add_item(logic [3:0] j, logic signed [15:0] act, logic signed [15:0] st,
                          logic signed [15:0] tg, bit te, bit rl, bit typed = 1'b0,
                          logic signed [15:0] cmd = '0, rhs_phase_e ph = PH_PASS);
    dir_row_t r;
    r = '{default: '0};
    r.it   = '{joint_index: j, policy_action: act, start_value: st, target_value: tg,
               tick_end: te, model_reloaded: rl};
    r.typed = typed;
    r.want  = '{out_joint: j, commanded_action: cmd, phase: ph, out_tick_end: te};
    dir_tab.insert(dir_tab.size(), r);
  endtask

  task automatic add_cfg(bit en, logic [15:0] rf, logic [15:0] df);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.en     = en;
    r.rf     = rf;
    r.df     = df;
    dir_tab.insert(dir_tab.size(), r);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (setpoints_due.size() == 0) begin
        flag_err($sformatf("unexpected result: joint %0d cmd %0d phase %0d end %0b",
                           out_item_o.out_joint, out_item_o.commanded_action,
                           out_item_o.phase, out_item_o.out_tick_end));
      end else begin
        want_res = setpoints_due.pop_front();
        if (out_item_o.out_joint !== want_res.out_joint ||
            out_item_o.commanded_action !== want_res.commanded_action ||
            out_item_o.phase !== want_res.phase ||
            out_item_o.out_tick_end !== want_res.out_tick_end) begin
          flag_err($sformatf({"result mismatch: want joint %0d cmd %0d phase %0d end %0b,",
                              " got joint %0d cmd %0d phase %0d end %0b"},
                             want_res.out_joint, want_res.commanded_action,
                             want_res.phase, want_res.out_tick_end,
                             out_item_o.out_joint, out_item_o.commanded_action,
                             out_item_o.phase, out_item_o.out_tick_end));
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rhs_in_t it;
    int      sent;
    int      nj;
    int      base;
    bit      cut_short;

    // Passthrough after reset: extremes, a tick end and a reload all echo the action.
    add_item(4'd0, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b1, 16'sh8000, PH_PASS);
    add_item(4'd15, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, 1'b1, 16'sh7FFF, PH_PASS);
    add_item(4'd5, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b1, 1'b0, 1'b1, 16'sh5555, PH_PASS);
    // Arm with full-scale spans in both directions, so the lerp sees both signs.
    add_cfg(1'b1, 16'd3, 16'd1);
    add_item(4'd0, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
    add_item(4'd15, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
    add_item(4'd0, 16'sh0000, 16'sh7FFF, 16'sh0000, 1'b0, 1'b0);
    add_item(4'd15, 16'sh0000, 16'sh8000, 16'sh0000, 1'b1, 1'b0);
    // Last ramp tick lands on the start value, then hold start, then the target.
    add_item(4'd0, 16'sh0100, 16'sh04D2, 16'sh0000, 1'b1, 1'b0, 1'b1, 16'sh04D2, PH_RAMP);
    add_item(4'd7, 16'sh0100, -16'sd77, 16'sh0000, 1'b1, 1'b0, 1'b1, -16'sd77, PH_HOLD);
    add_item(4'd3, 16'sh0100, 16'sh0000, 16'sh8000, 1'b0, 1'b0, 1'b1, 16'sh8000, PH_TARGET);
    add_item(4'd9, 16'sh0100, 16'sh0000, 16'sh7FFF, 1'b1, 1'b0, 1'b1, 16'sh7FFF, PH_TARGET);
    // Reload in mid tick: later joints re-capture, joint 0 keeps its older capture.
    add_item(4'd2, 16'sd500, -16'sd500, 16'sh0000, 1'b0, 1'b1);
    add_item(4'd15, -16'sd1000, 16'sd2000, 16'sh0000, 1'b1, 1'b0);
    add_item(4'd0, 16'sd7, 16'sd300, 16'sh0000, 1'b1, 1'b0);
    // Zero frame counts act as one tick each.
    add_cfg(1'b1, 16'd0, 16'd0);
    add_item(4'd4, 16'sh0000, 16'sd42, 16'sh0000, 1'b1, 1'b0, 1'b1, 16'sd42, PH_RAMP);
    add_item(4'd4, 16'sh0000, 16'sd43, 16'sh0000, 1'b1, 1'b0, 1'b1, 16'sd43, PH_HOLD);
    add_item(4'd4, 16'sh0000, 16'sh0000, 16'sd99, 1'b0, 1'b0, 1'b1, 16'sd99, PH_TARGET);
    // Disable: back to passthrough.
    add_cfg(1'b0, 16'd50, 16'd50);
    add_item(4'd8, 16'sd1, 16'sd5, 16'sd6, 1'b0, 1'b0, 1'b1, 16'sd1, PH_PASS);
    add_item(4'd8, -16'sd2, 16'sd5, 16'sd6, 1'b1, 1'b1, 1'b1, -16'sd2, PH_PASS);

    // Random phases; the first backs up the block, the last runs without idling.
    plan = '{'{1'b1, 16'd4, 16'd3}, '{1'b1, 16'hFFFF, 16'hFFFF}, '{1'b1, 16'd1, 16'd1},
             '{1'b1, 16'd0, 16'd0}, '{1'b0, 16'd7, 16'd9}, '{1'b1, 16'd2, 16'hFFFF},
             '{1'b1, 16'd16, 16'd2}, '{1'b1, 16'd3, 16'd5}};
    plan[6].rf = 16'($urandom_range(5, 40));
    plan[6].df = 16'($urandom_range(1, 12));

    // Hold reset, then release it at a falling edge.
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        drain_block();
        apply_cfg(dir_tab[i].en, dir_tab[i].rf, dir_tab[i].df);
      end else begin
        send_setpoint(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      apply_cfg(plan[p].en, plan[p].rf, plan[p].df);
      idle_on = (p != NUM_PHASES - 1) && ($urandom_range(3) != 0);
      if (p == 0) long_hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(7) == 0) begin
          // Noise: a lone item with every field at random.
          it.joint_index    = 4'($urandom);
          it.policy_action  = 16'($urandom);
          it.start_value    = 16'($urandom);
          it.target_value   = 16'($urandom);
          it.tick_end       = 1'($urandom);
          it.model_reloaded = ($urandom_range(3) == 0);
          send_setpoint(it, 1'b0, '0);
          sent++;
        end else begin
          // Well-formed tick of consecutive joints, now and then cut short.
          nj        = $urandom_range(1, 12);
          base      = $urandom_range(0, 16 - nj);
          cut_short = ($urandom_range(9) == 0);
          for (int k = 0; k < nj; k++) begin
            it.joint_index    = 4'(base + k);
            it.policy_action  = draw_q411();
            it.start_value    = draw_q411();
            it.target_value   = draw_q411();
            it.tick_end       = (k == nj - 1) && !cut_short;
            it.model_reloaded = (k == 0) ? ($urandom_range(15) == 0)
                                         : ($urandom_range(63) == 0);
            send_setpoint(it, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    drain_block();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/rhs_pkg.sv
hdl/rhs_cfg.sv
hdl/rhs_seq.sv
hdl/rhs_div.sv
hdl/ramp_hold_step_setpoint_sequencer.sv
tb/ramp_hold_step_setpoint_sequencer_tb.sv
